### hw/rtl/lcn_pkg.sv
// Package with the types, codes and constants of the list cursor navigator.
package lcn_pkg;

  localparam int unsigned VisibleRows = 17;
  localparam int unsigned HalfRows    = VisibleRows / 2;
  localparam logic [7:0]  Rows8       = 8'(VisibleRows);
  localparam logic [8:0]  Rows9       = 9'(VisibleRows);
  localparam logic [7:0]  Half8       = 8'(HalfRows);

  localparam logic [7:0] MoveKeys    = 8'h33;
  localparam logic [7:0] HoldMax     = 8'hFF;
  localparam logic [7:0] RepeatDelay = 8'd20;
  localparam logic [1:0] PhaseLast   = 2'd2;

  localparam int unsigned KeyUp    = 0;
  localparam int unsigned KeyDown  = 1;
  localparam int unsigned KeyEnter = 2;
  localparam int unsigned KeyEsc   = 3;
  localparam int unsigned KeyPgUp  = 4;
  localparam int unsigned KeyPgDn  = 5;
  localparam int unsigned KeyHome  = 6;
  localparam int unsigned KeyEnd   = 7;

  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  localparam logic CfgEntryCount = 1'b0;
  localparam logic CfgStartIndex = 1'b1;

  typedef enum logic [1:0] {
    OutContinue = 2'd0,
    OutBack     = 2'd1,
    OutPlay     = 2'd2,
    OutEmpty    = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [7:0] cursor;
    logic [7:0] top;
    logic [7:0] prev_keys;
    logic [7:0] hold;
    logic [1:0] phase;
    logic       open;
  } nav_state_t;

  typedef struct packed {
    logic [7:0] selection;
    logic [7:0] window_top;
    logic       redraw;
    outcome_e   outcome;
  } nav_result_t;

endpackage

### hw/rtl/lcn_in_if.sv
// Input channel interface carrying start and tick items.
interface lcn_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] key_bits;

  modport source (output valid, output opcode, output key_bits, input ready);
  modport sink (input valid, input opcode, input key_bits, output ready);
endinterface

### hw/rtl/lcn_out_if.sv
// Output channel interface carrying result items.
interface lcn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] selection;
  logic [7:0] window_top;
  logic       redraw;
  logic [1:0] outcome;

  modport source (output valid, output selection, output window_top, output redraw,
                  output outcome, input ready);
  modport sink (input valid, input selection, input window_top, input redraw,
                input outcome, output ready);
endinterface

### hw/rtl/lcn_step.sv
// Next-state and result logic for one item of the list cursor navigator.
module lcn_step (
  input  lcn_pkg::nav_state_t  cur_i,
  input  logic [7:0]           entry_count_i,
  input  logic [7:0]           start_index_i,
  input  logic                 opcode_i,
  input  logic [7:0]           key_bits_i,
  output lcn_pkg::nav_state_t  nxt_o,
  output lcn_pkg::nav_result_t res_o
);
  import lcn_pkg::*;

  always_comb begin
    logic [7:0] press;
    logic [7:0] sel;
    logic [7:0] top;
    logic [7:0] old;
    logic [8:0] sum9;
    logic       redraw;
    outcome_e   outcome;

    nxt_o   = cur_i;
    redraw  = 1'b0;
    outcome = OutContinue;
    press   = '0;
    sel     = '0;
    top     = '0;
    old     = cur_i.cursor;
    sum9    = '0;

    if (opcode_i == OpStart) begin
      sel = (start_index_i < entry_count_i) ? start_index_i : 8'd0;
      top = (sel > Half8) ? sel - Half8 : 8'd0;
      if (entry_count_i > Rows8 && top > entry_count_i - Rows8) begin
        top = entry_count_i - Rows8;
      end
      nxt_o.cursor    = sel;
      nxt_o.top       = top;
      nxt_o.prev_keys = 8'hFF;
      nxt_o.hold      = '0;
      nxt_o.phase     = '0;
      nxt_o.open      = 1'b1;
      redraw          = 1'b1;
    end else if (cur_i.open) begin
      press           = key_bits_i & ~cur_i.prev_keys;
      nxt_o.prev_keys = key_bits_i;
      if (|(key_bits_i & MoveKeys)) begin
        if (cur_i.hold != HoldMax) begin
          nxt_o.hold  = cur_i.hold + 8'd1;
          nxt_o.phase = (cur_i.phase == PhaseLast) ? 2'd0 : cur_i.phase + 2'd1;
        end
        if (nxt_o.hold > RepeatDelay && nxt_o.phase == 2'd0) begin
          press = press | (key_bits_i & MoveKeys);
        end
      end else begin
        nxt_o.hold  = '0;
        nxt_o.phase = '0;
      end

      if (press[KeyEsc]) begin
        nxt_o.open = 1'b0;
        outcome    = OutBack;
      end else if (press[KeyEnter]) begin
        nxt_o.open = 1'b0;
        outcome    = (entry_count_i != 8'd0) ? OutPlay : OutEmpty;
      end else if (entry_count_i != 8'd0) begin
        sel = cur_i.cursor;
        top = cur_i.top;
        if (press[KeyUp] && sel != 8'd0) begin
          sel = sel - 8'd1;
        end
        if (press[KeyDown] && ({1'b0, sel} + 9'd1) < {1'b0, entry_count_i}) begin
          sel = sel + 8'd1;
        end
        if (press[KeyPgUp]) begin
          sel = (sel > Rows8) ? sel - Rows8 : 8'd0;
        end
        if (press[KeyPgDn]) begin
          sum9 = {1'b0, sel} + Rows9;
          sel  = (sum9 < {1'b0, entry_count_i}) ? sum9[7:0] : entry_count_i - 8'd1;
        end
        if (press[KeyHome]) begin
          sel = 8'd0;
        end
        if (press[KeyEnd]) begin
          sel = entry_count_i - 8'd1;
        end
        if (sel != old) begin
          if (sel < top) begin
            top = sel;
          end
          if ({1'b0, sel} >= ({1'b0, top} + Rows9)) begin
            top = sel - Rows8 + 8'd1;
          end
          redraw = 1'b1;
        end
        nxt_o.cursor = sel;
        nxt_o.top    = top;
      end
    end

    res_o.selection  = nxt_o.cursor;
    res_o.window_top = nxt_o.top;
    res_o.redraw     = redraw;
    res_o.outcome    = outcome;
  end

endmodule

### hw/rtl/list_cursor_navigator_core.sv
// Top level of the list cursor navigator: state, configuration and result register.
//
//   Channel  Direction  Contents
//   in_i     sink       opcode, key_bits: one start or tick item
//   out_o    source     selection, window_top, redraw, outcome: one result per item
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i: entry_count and start_index
//
// Each item is handled by combinational step logic, and one item can be taken in every cycle unless a result waits.
// Its result appears in the output register on the cycle after it is accepted.
// The input is stalled only while a result waits in the output register.
// Reset clears the session, the cursor state and both configuration registers.
module list_cursor_navigator_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcn_in_if.sink         in_i,
  lcn_out_if.source      out_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [7:0]     cfg_data_i
);
  import lcn_pkg::*;

  nav_state_t  st_q, st_d;
  nav_result_t res_q, res_d;
  logic        out_valid_q;
  logic [7:0]  entry_count_q;
  logic [7:0]  start_index_q;
  logic        in_acc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  lcn_step u_step (
    .cur_i         (st_q),
    .entry_count_i (entry_count_q),
    .start_index_i (start_index_q),
    .opcode_i      (in_i.opcode),
    .key_bits_i    (in_i.key_bits),
    .nxt_o         (st_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      start_index_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEntryCount: entry_count_q <= cfg_data_i;
        CfgStartIndex: start_index_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{cursor: '0, top: '0, prev_keys: 8'hFF, hold: '0, phase: '0, open: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.selection  = res_q.selection;
  assign out_o.window_top = res_q.window_top;
  assign out_o.redraw     = res_q.redraw;
  assign out_o.outcome    = res_q.outcome;

`ifndef SYNTHESIS
  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.opcode == OpStart |=> st_q.open && out_valid_q && res_q.redraw)
    else $error("start item did not open a session");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.outcome != OutContinue |-> !st_q.open)
    else $error("session still open after a closing result");

  a_phase_tracks_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {6'd0, st_q.phase} == st_q.hold % 8'd3)
    else $error("repeat phase out of step with hold count");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid_q && !out_o.ready)
    else $error("input stalled without a waiting result");
`endif

endmodule

### tb/list_cursor_navigator_core_tb.sv
// Self-checking testbench for the list cursor navigator: directed, held-key and random sessions.
module list_cursor_navigator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcn_pkg::*;

  localparam int unsigned RepeatEvery = 3;
  localparam logic [7:0] UpMask    = 8'(1 << KeyUp);
  localparam logic [7:0] DownMask  = 8'(1 << KeyDown);
  localparam logic [7:0] EnterMask = 8'(1 << KeyEnter);
  localparam logic [7:0] EscMask   = 8'(1 << KeyEsc);
  localparam logic [7:0] PgUpMask  = 8'(1 << KeyPgUp);
  localparam logic [7:0] PgDnMask  = 8'(1 << KeyPgDn);
  localparam logic [7:0] HomeMask  = 8'(1 << KeyHome);
  localparam logic [7:0] EndMask   = 8'(1 << KeyEnd);

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  lcn_in_if  in_ch ();
  lcn_out_if out_ch ();

  list_cursor_navigator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [7:0]  entry_count  = 8'h00;
  logic [7:0]  start_index  = 8'h00;
  logic [7:0]  cursor       = 8'h00;
  logic [7:0]  top_row      = 8'h00;
  logic [7:0]  prev_keys    = 8'hFF;
  logic [7:0]  hold_ticks   = 8'h00;
  logic        session_open = 1'b0;
  nav_result_t pending_results[$];
  int          mismatch_count = 0;
  bit          in_gaps;
  bit          out_stalls;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic nav_result_t navigate(logic op, logic [7:0] keys);
    nav_result_t res;
    logic [7:0]  presses;
    int unsigned cur;
    int unsigned old;
    int unsigned top;
    int unsigned count;
    count = entry_count;
    res.redraw = 1'b0;
    res.outcome = OutContinue;
    if (op == OpStart) begin
      cur = (start_index < entry_count) ? start_index : 0;
      top = (cur > HalfRows) ? cur - HalfRows : 0;
      if (count > VisibleRows && top > count - VisibleRows) top = count - VisibleRows;
      cursor = 8'(cur);
      top_row = 8'(top);
      prev_keys = 8'hFF;
      hold_ticks = 8'h00;
      session_open = 1'b1;
      res.redraw = 1'b1;
    end else if (session_open) begin
      presses = keys & ~prev_keys;
      prev_keys = keys;
      if ((keys & MoveKeys) != 8'h00) begin
        if (hold_ticks != HoldMax) hold_ticks++;
        if (hold_ticks > RepeatDelay && hold_ticks % RepeatEvery == 0)
          presses |= keys & MoveKeys;
      end else begin
        hold_ticks = 8'h00;
      end
      if (presses[KeyEsc]) begin
        session_open = 1'b0;
        res.outcome = OutBack;
      end else if (presses[KeyEnter]) begin
        session_open = 1'b0;
        res.outcome = (count != 0) ? OutPlay : OutEmpty;
      end else if (count != 0) begin
        cur = cursor;
        old = cur;
        top = top_row;
        if (presses[KeyUp] && cur != 0) cur--;
        if (presses[KeyDown] && cur + 1 < count) cur++;
        if (presses[KeyPgUp]) cur = (cur > VisibleRows) ? cur - VisibleRows : 0;
        if (presses[KeyPgDn]) cur = (cur + VisibleRows < count) ? cur + VisibleRows : count - 1;
        if (presses[KeyHome]) cur = 0;
        if (presses[KeyEnd]) cur = count - 1;
        if (cur != old) begin
          if (cur < top) top = cur;
          if (cur >= top + VisibleRows) top = cur - VisibleRows + 1;
          cursor = 8'(cur);
          top_row = 8'(top);
          res.redraw = 1'b1;
        end
      end
    end
    res.selection = cursor;
    res.window_top = top_row;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < 40) $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    nav_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", out_ch.selection, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.selection !== want.selection)
          report_mismatch("selection", out_ch.selection, want.selection);
        if (out_ch.window_top !== want.window_top)
          report_mismatch("window_top", out_ch.window_top, want.window_top);
        if (out_ch.redraw !== want.redraw)
          report_mismatch("redraw", 8'(out_ch.redraw), 8'(want.redraw));
        if (out_ch.outcome !== want.outcome)
          report_mismatch("outcome", 8'(out_ch.outcome), 8'(want.outcome));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (out_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(logic op, logic [7:0] keys);
    @(negedge clk_i);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key_bits <= keys;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_results.push_back(navigate(op, keys));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgEntryCount) entry_count = value;
    else start_index = value;
  endtask

  task automatic configure(logic [7:0] count, logic [7:0] first);
    settle();
    write_register(CfgEntryCount, count);
    write_register(CfgStartIndex, first);
  endtask

  function automatic logic [7:0] nav_key(bit move_only);
    case ($urandom_range(0, move_only ? 3 : 5))
      0: return UpMask;
      1: return DownMask;
      2: return PgUpMask;
      3: return PgDnMask;
      4: return HomeMask;
      default: return EndMask;
    endcase
  endfunction

  function automatic logic [7:0] next_keys(logic [7:0] held);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return 8'h00;
    if (pick < 50) return held;
    if (pick < 80) return nav_key(1'b0);
    if (pick < 88) return nav_key(1'b1) | nav_key(1'b1);
    if (pick < 93) return 8'($urandom) | ($urandom_range(0, 1) ? EnterMask : EscMask);
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'(VisibleRows);
      3: return 8'(VisibleRows + 1);
      4: return 8'hFF;
      default: return 8'($urandom_range(2, 254));
    endcase
  endfunction

  function automatic logic [7:0] pick_start(logic [7:0] count);
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return (count == 0) ? 8'h00 : count - 8'h01;
      default: return (count == 0) ? 8'h00 : 8'($urandom_range(0, count - 1));
    endcase
  endfunction

  task automatic test_empty_list();
    send_item(OpTick, UpMask);
    send_item(OpStart, 8'h00);
    send_item(OpTick, 8'h00);
    send_item(OpTick, 8'hF3);
    send_item(OpTick, EnterMask);
    send_item(OpTick, EnterMask);
  endtask

  task automatic test_each_key();
    configure(8'd40, 8'd30);
    send_item(OpStart, 8'hFF);
    send_item(OpTick, 8'h00);
    send_item(OpTick, UpMask);
    send_item(OpTick, DownMask);
    send_item(OpTick, PgUpMask);
    send_item(OpTick, PgDnMask);
    send_item(OpTick, HomeMask);
    send_item(OpTick, EndMask);
    send_item(OpTick, 8'hFF);
  endtask

  task automatic test_session_ends();
    send_item(OpStart, 8'h00);
    send_item(OpTick, 8'h00);
    send_item(OpTick, EscMask | EnterMask);
    send_item(OpStart, 8'h00);
    send_item(OpStart, 8'h00);
    send_item(OpTick, 8'h00);
    send_item(OpTick, EnterMask);
  endtask

  task automatic test_config_extremes();
    configure(8'hFF, 8'hFF);
    send_item(OpStart, 8'h00);
    send_item(OpTick, EndMask);
    configure(8'hFF, 8'hFE);
    send_item(OpStart, 8'h00);
  endtask

  task automatic test_register_change();
    configure(8'd100, 8'd90);
    send_item(OpStart, 8'h00);
    send_item(OpTick, EndMask);
    configure(8'd20, 8'd0);
    send_item(OpTick, DownMask);
    send_item(OpTick, PgDnMask);
  endtask

  task automatic test_key_hold();
    logic [7:0] keys;
    configure(8'hFF, 8'h80);
    send_item(OpStart, 8'h00);
    send_item(OpTick, 8'h00);
    for (int run = 0; run < 4; run++) begin
      keys = nav_key(1'b1) | ($urandom_range(0, 1) ? nav_key(1'b1) : 8'h00);
      repeat ((run == 0) ? 270 : $urandom_range(21, 70)) send_item(OpTick, keys);
      send_item(OpTick, 8'h00);
    end
  endtask

  task automatic test_random_sessions();
    int         counted;
    int         ticks;
    int         span;
    logic [7:0] keys;
    logic [7:0] count;
    counted = 0;
    while (counted < 1000) begin
      if (counted >= 850) begin
        in_gaps = 1'b0;
        out_stalls = 1'b0;
      end else begin
        in_gaps = $urandom_range(0, 3) != 0;
        out_stalls = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        count = pick_count();
        configure(count, pick_start(count));
      end
      send_item(OpStart, 8'($urandom));
      counted++;
      keys = 8'h00;
      ticks = 0;
      span = $urandom_range(5, 60);
      while (session_open && ticks < span) begin
        case ($urandom_range(0, 39))
          0: begin
            count = pick_count();
            configure(count, pick_start(count));
          end
          1: begin
            send_item(OpStart, 8'($urandom));
            counted++;
          end
          2: begin
            keys = nav_key(1'b1) | ($urandom_range(0, 1) ? nav_key(1'b1) : 8'h00);
            repeat ($urandom_range(21, 70)) begin
              send_item(OpTick, keys);
              counted++;
            end
          end
          default: begin
            keys = next_keys(keys);
            send_item(OpTick, keys);
            counted++;
          end
        endcase
        ticks++;
      end
      repeat ($urandom_range(0, 2)) send_item(OpTick, 8'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgEntryCount;
    cfg_data_i = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.opcode = OpTick;
    in_ch.key_bits = 8'h00;
    in_gaps = 1'b1;
    out_stalls = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_each_key();
    test_session_ends();
    test_config_extremes();
    test_register_change();
    test_key_hold();
    test_random_sessions();

    in_gaps = 1'b0;
    out_stalls = 1'b0;
    settle();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("list_cursor_navigator_core_tb passed");
    end else begin
      $display("list_cursor_navigator_core_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("list_cursor_navigator_core_tb failed");
    $finish;
  end

endmodule

### list_cursor_navigator_core.f
hw/rtl/lcn_pkg.sv
hw/rtl/lcn_in_if.sv
hw/rtl/lcn_out_if.sv
hw/rtl/lcn_step.sv
hw/rtl/list_cursor_navigator_core.sv
tb/list_cursor_navigator_core_tb.sv
